FILE: rtl/pwub_pkg.sv
package pwub_pkg;

  localparam int WEIGHT_W = 32;
  localparam int CFG_IDX_W = 1;
  localparam int CFG_DATA_W = 32;
  localparam int PLEX_K_W = 5;

  localparam logic [CFG_IDX_W-1:0] CFG_PLEX_K      = 1'b0;
  localparam logic [CFG_IDX_W-1:0] CFG_BEST_WEIGHT = 1'b1;

  localparam logic [PLEX_K_W-1:0] PLEX_K_RESET = 5'd2;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_NBR,
    ST_SCAN,
    ST_MUL,
    ST_CMP,
    ST_FIN,
    ST_SUM,
    ST_OUT
  } state_t;

endpackage

FILE: rtl/pwub_store.sv
module pwub_store #(
  parameter int DEPTH = 15,
  parameter int AW    = 4
) (
  input  logic          clk,
  input  logic          wr_en,
  input  logic [AW-1:0] wr_addr,
  input  logic [31:0]   wr_data,
  input  logic [AW-1:0] rd_addr,
  output logic [31:0]   rd_data
);

  logic [31:0] mem [DEPTH];
  logic [31:0] rd_data_r;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    rd_data_r <= mem[rd_addr];
  end

  assign rd_data = rd_data_r;

endmodule

FILE: rtl/plex_weight_upper_bound.sv
// Channel   Dir   Handshake             Payload
// in_*      in    in_tvalid/in_tready   tdata: item_weight; tuser: is_root, is_neighbor;
//                                       tlast: last
// out_*     out   out_tvalid/out_tready tdata: bound; tuser: early_stop
// cfg_*     in    cfg_wr_en             cfg_index selects plex_k or best_weight
//
// Root, stored and ignored items are taken in the idle state and neighbor items add an
// accumulate state; a non-neighbor that meets a full store scans it through the single
// store read port and, when it beats the minimum, multiplies and compares. A last item
// also adds a sum pass over the store (skipped when frozen), plus any output stall.
// One saturating adder/comparator serves neighbor, displacement and final sums.
// rst_n is synchronous, active low. A result waits in the output register; the
// block stalls in its output state only if a new result finds that register full.
module plex_weight_upper_bound #(
  parameter int MAX_K = 16
) (
  input  logic                                 clk,
  input  logic                                 rst_n,
  input  logic                                 in_tvalid,
  output logic                                 in_tready,
  input  logic [31:0]                          in_tdata,  // [31:0] item_weight
  input  logic [1:0]                           in_tuser,  // [0] is_root, [1] is_neighbor
  input  logic                                 in_tlast,
  output logic                                 out_tvalid,
  input  logic                                 out_tready,
  output logic [31:0]                          out_tdata, // [31:0] bound
  output logic                                 out_tuser, // [0] early_stop
  input  logic                                 cfg_wr_en,
  input  logic [pwub_pkg::CFG_IDX_W-1:0]       cfg_index,
  input  logic [pwub_pkg::CFG_DATA_W-1:0]      cfg_wdata
);

  import pwub_pkg::*;

  localparam int DEPTH = MAX_K - 1;
  localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNTW  = $clog2(MAX_K);
  localparam int PW    = WEIGHT_W + CNTW;

  state_t state_r, state_nxt;

  logic [PLEX_K_W-1:0] plex_k_r;
  logic [31:0]         best_r;
  logic [31:0]         w_r;
  logic                last_r;
  logic [31:0]         bound_r;
  logic                frozen_r;
  logic [CNTW-1:0]     count_r;
  logic [CNTW-1:0]     idx_r;
  logic                pend_r;
  logic [CNTW-1:0]     pend_idx_r;
  logic [31:0]         min_val_r;
  logic [CNTW-1:0]     min_idx_r;
  logic                min_vld_r;
  logic [PW-1:0]       prod_r;
  logic [31:0]         acc_r;
  logic                out_valid_r;
  logic [31:0]         out_bound_r;
  logic                out_early_r;

  logic [CNTW-1:0] cap;
  logic            accept;
  logic            in_root;
  logic            in_nbr;
  logic            can_insert;
  logic            scan_done;
  logic            out_free;
  logic [31:0]     prod_sat;
  logic [31:0]     alu_a;
  logic [31:0]     alu_b;
  logic [32:0]     alu_raw;
  logic [31:0]     alu_sum;
  logic            alu_gt;

  logic            st_wr_en;
  logic [AW-1:0]   st_wr_addr;
  logic [31:0]     st_wr_data;
  logic [AW-1:0]   st_rd_addr;
  logic [31:0]     st_rd_data;

  pwub_store #(
    .DEPTH (DEPTH),
    .AW    (AW)
  ) u_store (
    .clk     (clk),
    .wr_en   (st_wr_en),
    .wr_addr (st_wr_addr),
    .wr_data (st_wr_data),
    .rd_addr (st_rd_addr),
    .rd_data (st_rd_data)
  );

  always_comb begin
    if (plex_k_r < 5'd2) begin
      cap = CNTW'(1);
    end else if (int'(plex_k_r) > MAX_K) begin
      cap = CNTW'(DEPTH);
    end else begin
      cap = CNTW'(plex_k_r - 5'd1);
    end
  end

  assign in_tready  = (state_r == ST_IDLE);
  assign accept     = in_tvalid && in_tready;
  assign in_root    = in_tuser[0];
  assign in_nbr     = in_tuser[1];
  assign can_insert = (count_r < cap) && (count_r < CNTW'(DEPTH));
  assign scan_done  = !pend_r && (idx_r >= count_r);
  assign out_free   = !out_valid_r || out_tready;
  assign prod_sat   = (|prod_r[PW-1:WEIGHT_W]) ? 32'hFFFF_FFFF : prod_r[31:0];

  // shared saturating adder and threshold compare
  always_comb begin
    case (state_r)
      ST_CMP: begin
        alu_a = prod_sat;
        alu_b = bound_r;
      end
      ST_SUM: begin
        alu_a = acc_r;
        alu_b = st_rd_data;
      end
      default: begin
        alu_a = bound_r;
        alu_b = w_r;
      end
    endcase
    alu_raw = {1'b0, alu_a} + {1'b0, alu_b};
    alu_sum = alu_raw[32] ? 32'hFFFF_FFFF : alu_raw[31:0];
    alu_gt  = alu_sum > best_r;
  end

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ST_IDLE: begin
        if (accept) begin
          if (in_root || frozen_r || (!in_nbr && can_insert)) begin
            state_nxt = in_tlast ? ST_FIN : ST_IDLE;
          end else if (in_nbr) begin
            state_nxt = ST_NBR;
          end else begin
            state_nxt = ST_SCAN;
          end
        end
      end
      ST_NBR:  state_nxt = last_r ? ST_FIN : ST_IDLE;
      ST_SCAN: begin
        if (scan_done) begin
          if (w_r > min_val_r) begin
            state_nxt = ST_MUL;
          end else begin
            state_nxt = last_r ? ST_FIN : ST_IDLE;
          end
        end
      end
      ST_MUL:  state_nxt = ST_CMP;
      ST_CMP:  state_nxt = last_r ? ST_FIN : ST_IDLE;
      ST_FIN:  state_nxt = frozen_r ? ST_OUT : ST_SUM;
      ST_SUM:  state_nxt = scan_done ? ST_OUT : ST_SUM;
      ST_OUT:  state_nxt = out_free ? ST_IDLE : ST_OUT;
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_comb begin
    st_wr_en   = 1'b0;
    st_wr_addr = count_r[AW-1:0];
    st_wr_data = in_tdata;
    st_rd_addr = idx_r[AW-1:0];
    case (state_r)
      ST_IDLE: begin
        st_wr_en = accept && !in_root && !frozen_r && !in_nbr && can_insert;
      end
      ST_CMP: begin
        st_wr_en   = !alu_gt;
        st_wr_addr = min_idx_r[AW-1:0];
        st_wr_data = w_r;
      end
      default: begin
        st_wr_en = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      plex_k_r <= PLEX_K_RESET;
      best_r   <= '0;
    end else if (cfg_wr_en) begin
      case (cfg_index)
        CFG_PLEX_K:      plex_k_r <= cfg_wdata[PLEX_K_W-1:0];
        CFG_BEST_WEIGHT: best_r   <= cfg_wdata;
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      bound_r     <= '0;
      frozen_r    <= 1'b0;
      count_r     <= '0;
      pend_r      <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      if ((state_r == ST_OUT) && out_free) begin
        out_valid_r <= 1'b1;
      end else if (out_tready) begin
        out_valid_r <= 1'b0;
      end
      case (state_r)
        ST_IDLE: begin
          if (accept) begin
            w_r    <= in_tdata;
            last_r <= in_tlast;
            idx_r  <= '0;
            pend_r <= 1'b0;
            min_vld_r <= 1'b0;
            if (in_root) begin
              bound_r  <= in_tdata;
              count_r  <= '0;
              frozen_r <= 1'b0;
            end else if (!frozen_r && !in_nbr && can_insert) begin
              count_r <= count_r + CNTW'(1);
            end
          end
        end
        ST_NBR: begin
          bound_r <= alu_sum;
          if (alu_gt) begin
            frozen_r <= 1'b1;
          end
        end
        ST_SCAN: begin
          if (pend_r && (!min_vld_r || st_rd_data < min_val_r)) begin
            min_val_r <= st_rd_data;
            min_idx_r <= pend_idx_r;
          end
          if (pend_r) begin
            min_vld_r <= 1'b1;
          end
          if (idx_r < count_r) begin
            idx_r      <= idx_r + CNTW'(1);
            pend_r     <= 1'b1;
            pend_idx_r <= idx_r;
          end else begin
            pend_r <= 1'b0;
          end
        end
        ST_MUL: begin
          prod_r <= PW'(w_r) * PW'(cap);
        end
        ST_CMP: begin
          if (alu_gt) begin
            bound_r  <= alu_sum;
            frozen_r <= 1'b1;
          end
        end
        ST_FIN: begin
          acc_r  <= bound_r;
          idx_r  <= '0;
          pend_r <= 1'b0;
        end
        ST_SUM: begin
          if (pend_r) begin
            acc_r <= alu_sum;
          end
          if (idx_r < count_r) begin
            idx_r  <= idx_r + CNTW'(1);
            pend_r <= 1'b1;
          end else begin
            pend_r <= 1'b0;
          end
        end
        ST_OUT: begin
          if (out_free) begin
            out_bound_r <= acc_r;
            out_early_r <= frozen_r;
          end
        end
        default: begin
        end
      endcase
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_bound_r;
  assign out_tuser  = out_early_r;

endmodule
